// ===== hdl/mbbp_pkg.sv =====
package mbbp_pkg;

	localparam int MAX_TOKEN   = 48;
	localparam int TAIL_LIMIT  = 1024;
	localparam int WIN_DEPTH   = MAX_TOKEN + 4;
	localparam int FILL_W      = $clog2(WIN_DEPTH + 1);
	localparam int CNT_W       = $clog2(TAIL_LIMIT + 2);
	localparam int TOKEN_WORDS = 6;
	localparam int TOKEN_BYTES = 8 * TOKEN_WORDS;
	localparam int SIZE_W      = 48;
	localparam int TLEN_W      = 6;
	localparam int WORD_W      = 64;
	localparam int REG_IDX_W   = 3;
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = $clog2(QDEPTH + 1);

	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_HYPHEN = 8'h2D;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_TOKEN_LENGTH  = 3'd0,
		REG_TOKEN_WORD_0  = 3'd1,
		REG_TOKEN_WORD_1  = 3'd2,
		REG_TOKEN_WORD_2  = 3'd3,
		REG_TOKEN_WORD_3  = 3'd4,
		REG_TOKEN_WORD_4  = 3'd5,
		REG_TOKEN_WORD_5  = 3'd6,
		REG_EXPECTED_SIZE = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_PAYLOAD  = 3'd0,
		ST_OK       = 3'd1,
		ST_TRAILING = 3'd2,
		ST_HEADER   = 3'd3,
		ST_SIZE     = 3'd4
	} status_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [2:0] status;
		logic       is_last;
	} result_t;

	typedef struct packed {
		logic    pay_vld;
		result_t pay;
		logic    end_vld;
		result_t fin;
	} push_t;

	typedef struct packed {
		logic step;
		logic pop;
		logic ins;
		logic ins_up;
		logic active;
	} cell_ctl_t;

endpackage

// ===== hdl/mbbp_ifs.sv =====
interface mbbp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_response;

	modport source (output valid, output in_byte, output end_of_response, input ready);
	modport sink (input valid, input in_byte, input end_of_response, output ready);
endinterface

interface mbbp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [2:0] status;
	logic       is_last;

	modport source (output valid, output out_byte, output status, output is_last, input ready);
	modport sink (input valid, input out_byte, input status, input is_last, output ready);
endinterface

interface mbbp_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [63:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/mbbp_cell.sv =====
module mbbp_cell (
	input  logic                clk,
	input  mbbp_pkg::cell_ctl_t ctl,
	input  logic [7:0]          new_byte,
	input  logic [7:0]          up_byte,
	input  logic [7:0]          bnd_byte,
	output logic [7:0]          held_byte,
	output logic [7:0]          cur_byte,
	output logic                eq
);

	logic [7:0] byte_q;

	assign held_byte = byte_q;
	assign cur_byte  = ctl.ins ? new_byte : byte_q;
	assign eq        = !ctl.active || (cur_byte == bnd_byte);

	always_ff @(posedge clk) begin
		if (ctl.step) begin
			if (ctl.pop) begin
				byte_q <= ctl.ins_up ? new_byte : up_byte;
			end else begin
				byte_q <= cur_byte;
			end
		end
	end

endmodule

// ===== hdl/mbbp_outq.sv =====
module mbbp_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  mbbp_pkg::push_t     push,
	output logic                room,
	mbbp_out_if.source          out_ch
);

	mbbp_pkg::result_t                    mem_q [mbbp_pkg::QDEPTH];
	logic [mbbp_pkg::QPTR_W-1:0]          wr_q;
	logic [mbbp_pkg::QPTR_W-1:0]          rd_q;
	logic [mbbp_pkg::QCNT_W-1:0]          cnt_q;
	mbbp_pkg::result_t                    first;
	logic [1:0]                           n_push;
	logic                                 pop;

	always_comb begin
		first  = push.pay_vld ? push.pay : push.fin;
		n_push = 2'(push.pay_vld) + 2'(push.end_vld);
	end

	assign pop              = out_ch.valid && out_ch.ready;
	assign room             = cnt_q <= mbbp_pkg::QCNT_W'(mbbp_pkg::QDEPTH - 2);
	assign out_ch.valid     = cnt_q != '0;
	assign out_ch.out_byte  = mem_q[rd_q].out_byte;
	assign out_ch.status    = mem_q[rd_q].status;
	assign out_ch.is_last   = mem_q[rd_q].is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + mbbp_pkg::QPTR_W'(n_push);
			rd_q  <= rd_q + mbbp_pkg::QPTR_W'(pop);
			cnt_q <= cnt_q + mbbp_pkg::QCNT_W'(n_push) - mbbp_pkg::QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			mem_q[wr_q] <= first;
		end
		if (n_push == 2'd2) begin
			mem_q[wr_q + mbbp_pkg::QPTR_W'(1)] <= push.fin;
		end
	end

endmodule

// ===== hdl/multipart_byterange_body_parser.sv =====
// A result word is written into the output queue when its body byte is accepted and is offered from the queue in order.
// Throughput: one body byte per cycle; the end-of-response byte can give two
// words, and input stalls while the output queue holds more than two words.
// The boundary window is a row of byte cells compared in parallel, combinationally.
// Reset (arst_n low, async) clears parser state, queue and registers to their
// defaults; window cell bytes are not reset.
module multipart_byterange_body_parser (
	input  logic         clk,
	input  logic         arst_n,
	mbbp_in_if.sink      body_in,
	mbbp_out_if.source   result_out,
	mbbp_cfg_if.sink     cfg
);

	typedef enum logic [2:0] {
		M_PAYLOAD,
		M_AFTER0,
		M_AFTER1,
		M_HEADER,
		M_FINAL,
		M_HDRERR
	} mode_t;

	localparam int FW = mbbp_pkg::FILL_W;
	localparam int CW = mbbp_pkg::CNT_W;
	localparam int WD = mbbp_pkg::WIN_DEPTH;

	logic [mbbp_pkg::TLEN_W-1:0]   tlen_q;
	logic [mbbp_pkg::WORD_W-1:0]   tok_q [mbbp_pkg::TOKEN_WORDS];
	logic [mbbp_pkg::SIZE_W-1:0]   exp_q;

	mode_t                         mode_q, mode_nx;
	logic [FW-1:0]                 fill_q, fill_nx;
	logic [7:0]                    fab_q, fab_nx;
	logic [1:0]                    crlf_q, crlf_nx;
	logic [CW-1:0]                 hc_q, hc_nx;
	logic [CW-1:0]                 tail_q, tail_nx;
	logic [mbbp_pkg::SIZE_W-1:0]   wr_q, wr_nx;

	logic                          accept;
	logic                          room;
	logic [FW-1:0]                 blen;
	logic [FW-1:0]                 fill_ins;
	logic                          check;
	logic                          match;
	logic                          emit;
	logic                          pop;
	logic [CW-1:0]                 hc_inc;
	logic [2:0]                    f1, f2, fh;
	mbbp_pkg::status_t             st;
	mbbp_pkg::push_t               push;

	logic [7:0]                    held [WD];
	logic [7:0]                    cur [WD];
	logic [WD-1:0]                 eq;

	function automatic logic [2:0] crlf_feed(input logic [1:0] p, input logic [7:0] b);
		logic [7:0] want;
		logic [2:0] r;
		want = p[0] ? mbbp_pkg::CH_LF : mbbp_pkg::CH_CR;
		if (b == want) begin
			r = (p == 2'd3) ? 3'b100 : {1'b0, p + 2'd1};
		end else begin
			r = {2'b00, b == mbbp_pkg::CH_CR};
		end
		return r;
	endfunction

	assign cfg.ready    = 1'b1;
	assign body_in.ready = room;
	assign accept       = body_in.valid && room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tlen_q <= mbbp_pkg::TLEN_W'(1);
			exp_q  <= '0;
			for (int w = 0; w < mbbp_pkg::TOKEN_WORDS; w++) begin
				tok_q[w] <= '0;
			end
		end else if (cfg.valid) begin
			case (mbbp_pkg::reg_idx_t'(cfg.index))
				mbbp_pkg::REG_TOKEN_LENGTH: begin
					tlen_q <= cfg.data[mbbp_pkg::TLEN_W-1:0];
				end
				mbbp_pkg::REG_EXPECTED_SIZE: begin
					exp_q <= cfg.data[mbbp_pkg::SIZE_W-1:0];
				end
				default: begin
					tok_q[cfg.index - 3'(mbbp_pkg::REG_TOKEN_WORD_0)] <= cfg.data;
				end
			endcase
		end
	end

	always_comb begin
		if (tlen_q == '0) begin
			blen = FW'(5);
		end else if (int'(tlen_q) > mbbp_pkg::MAX_TOKEN) begin
			blen = FW'(mbbp_pkg::MAX_TOKEN + 4);
		end else begin
			blen = FW'(tlen_q) + FW'(4);
		end
	end

	assign fill_ins = (fill_q < FW'(WD)) ? fill_q + FW'(1) : fill_q;
	assign check    = fill_ins >= blen;
	assign match    = &eq;
	assign pop      = check && !match;
	assign emit     = accept && (mode_q == M_PAYLOAD) && pop && (wr_q < exp_q);

	for (genvar i = 0; i < WD; i++) begin : g_cell
		mbbp_pkg::cell_ctl_t ctl;
		logic [7:0]          bnd;
		logic [7:0]          up;

		if (i == 0) begin : g_b
			assign bnd = mbbp_pkg::CH_CR;
		end else if (i == 1) begin : g_b
			assign bnd = mbbp_pkg::CH_LF;
		end else if (i < 4) begin : g_b
			assign bnd = mbbp_pkg::CH_HYPHEN;
		end else if (i - 4 < mbbp_pkg::TOKEN_BYTES) begin : g_b
			assign bnd = tok_q[(i - 4) / 8][((i - 4) % 8) * 8 +: 8];
		end else begin : g_b
			assign bnd = 8'h00;
		end

		if (i == WD - 1) begin : g_u
			assign up         = 8'h00;
			assign ctl.ins_up = 1'b0;
		end else begin : g_u
			assign up         = held[i+1];
			assign ctl.ins_up = fill_q == FW'(i + 1);
		end

		assign ctl.step   = accept && (mode_q == M_PAYLOAD);
		assign ctl.pop    = pop;
		assign ctl.ins    = fill_q == FW'(i);
		assign ctl.active = FW'(i) < blen;

		mbbp_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.new_byte  (body_in.in_byte),
			.up_byte   (up),
			.bnd_byte  (bnd),
			.held_byte (held[i]),
			.cur_byte  (cur[i]),
			.eq        (eq[i])
		);
	end

	always_comb begin
		mode_nx = mode_q;
		fill_nx = fill_q;
		fab_nx  = fab_q;
		crlf_nx = crlf_q;
		hc_nx   = hc_q;
		tail_nx = tail_q;
		wr_nx   = emit ? wr_q + mbbp_pkg::SIZE_W'(1) : wr_q;
		hc_inc  = (hc_q < CW'(mbbp_pkg::TAIL_LIMIT)) ? hc_q + CW'(1) : hc_q;
		f1      = crlf_feed(2'd0, fab_q);
		f2      = crlf_feed(f1[1:0], body_in.in_byte);
		fh      = crlf_feed(crlf_q, body_in.in_byte);
		case (mode_q)
			M_PAYLOAD: begin
				if (!check) begin
					fill_nx = fill_ins;
				end else if (match) begin
					fill_nx = '0;
					mode_nx = M_AFTER0;
				end else begin
					fill_nx = fill_ins - FW'(1);
				end
			end
			M_AFTER0: begin
				fab_nx  = body_in.in_byte;
				mode_nx = M_AFTER1;
			end
			M_AFTER1: begin
				if (fab_q == mbbp_pkg::CH_HYPHEN && body_in.in_byte == mbbp_pkg::CH_HYPHEN) begin
					tail_nx = '0;
					mode_nx = M_FINAL;
				end else begin
					crlf_nx = f2[1:0];
					hc_nx   = CW'(2);
					mode_nx = M_HEADER;
				end
			end
			M_HEADER: begin
				hc_nx   = hc_inc;
				crlf_nx = fh[1:0];
				if (fh[2]) begin
					fill_nx = '0;
					hc_nx   = '0;
					mode_nx = M_PAYLOAD;
				end else if (hc_inc >= CW'(mbbp_pkg::TAIL_LIMIT)) begin
					mode_nx = M_HDRERR;
				end
			end
			M_FINAL: begin
				if (tail_q <= CW'(mbbp_pkg::TAIL_LIMIT)) begin
					tail_nx = tail_q + CW'(1);
				end
			end
			default: begin
			end
		endcase

		if (mode_nx == M_HDRERR || mode_nx == M_HEADER || mode_nx == M_AFTER0 ||
				mode_nx == M_AFTER1) begin
			st = mbbp_pkg::ST_HEADER;
		end else if (mode_nx == M_FINAL && tail_nx > CW'(mbbp_pkg::TAIL_LIMIT)) begin
			st = mbbp_pkg::ST_TRAILING;
		end else if (wr_nx != exp_q) begin
			st = mbbp_pkg::ST_SIZE;
		end else begin
			st = mbbp_pkg::ST_OK;
		end

		push.pay_vld          = emit;
		push.pay.out_byte     = cur[0];
		push.pay.status       = mbbp_pkg::ST_PAYLOAD;
		push.pay.is_last      = 1'b0;
		push.end_vld          = accept && body_in.end_of_response;
		push.fin.out_byte     = 8'h00;
		push.fin.status       = st;
		push.fin.is_last      = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_PAYLOAD;
			fill_q <= '0;
			fab_q  <= '0;
			crlf_q <= '0;
			hc_q   <= '0;
			tail_q <= '0;
			wr_q   <= '0;
		end else if (accept) begin
			if (body_in.end_of_response) begin
				mode_q <= M_PAYLOAD;
				fill_q <= '0;
				fab_q  <= '0;
				crlf_q <= '0;
				hc_q   <= '0;
				tail_q <= '0;
				wr_q   <= '0;
			end else begin
				mode_q <= mode_nx;
				fill_q <= fill_nx;
				fab_q  <= fab_nx;
				crlf_q <= crlf_nx;
				hc_q   <= hc_nx;
				tail_q <= tail_nx;
				wr_q   <= wr_nx;
			end
		end
	end

	mbbp_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.out_ch (result_out)
	);

endmodule
